// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define BBCM_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// expression must never be true outside reset
`define BBCM_ASSERT_NEVER(lbl, ck, rn, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) else $error(msg);

`endif

// ===== rtl/core/bbcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Buffer cache manager package
// Function and status codes, sequencer states and port widths.
// ----------------------------------------------------------------------------
package bbcm_pkg;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 3;

  localparam logic [1:0] FN_GET   = 2'd0;
  localparam logic [1:0] FN_REL   = 2'd1;
  localparam logic [1:0] FN_FLAGS = 2'd2;
  localparam logic [1:0] FN_NONE  = 2'd3;

  localparam logic [2:0] STAT_HIT     = 3'd0;
  localparam logic [2:0] STAT_MISS    = 3'd1;
  localparam logic [2:0] STAT_NONE    = 3'd2;
  localparam logic [2:0] STAT_LOCKED  = 3'd3;
  localparam logic [2:0] STAT_REL     = 3'd4;
  localparam logic [2:0] STAT_REL_ERR = 3'd5;
  localparam logic [2:0] STAT_FLAGS   = 3'd6;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OP,
    S_MATCH,
    S_WALK,
    S_DECIDE,
    S_SPLICE_RD,
    S_SPLICE_WR,
    S_FILL
  } state_t;

  typedef enum logic [1:0] {
    SP_HEAD,
    SP_PREV,
    SP_NEXT,
    SP_TAIL
  } splice_step_t;

  function automatic logic [1:0] badness(input logic dirty, input logic locked);
    return {dirty, locked};
  endfunction

endpackage

// ===== rtl/core/bbcm_ram.sv =====
// ----------------------------------------------------------------------------
// Buffer descriptor RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbcm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/block_buffer_cache_manager_top.sv =====
// ----------------------------------------------------------------------------
// Block buffer cache manager
// Buffer pool with tag lookup, reference counts and a victim ring in fill order.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the in_ stream (func in in_tuser), one result per
// request leaves on the out_ stream (status in out_tuser); func 3 is dropped.
// All buffer descriptors sit in one RAM with a single read and a single write
// port; a small sequencer steps through it one entry per cycle.
// Steps: a refused get or out-of-range buffer is answered from the idle state;
// release and set flags read the entry, then write it back; a get compares
// tags entry by entry from buffer 0 and stops on a hit; a miss then walks the
// ring from the head, up to NUM_BUFFERS entries, and splices the victim to the
// ring tail, either in place or through the splice read and write states.
// The RAM port and the dependent ring pointer chase make these steps serial.
// One request is in flight at a time; in_tready is high only when the
// sequencer is idle and the result register is empty.
// After reset a clearing pass writes every descriptor; no request is taken
// meanwhile. A stalled receiver holds the result in the output register and
// blocks further requests.
// ----------------------------------------------------------------------------
module block_buffer_cache_manager_top #(
  parameter int NUM_BUFFERS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // dev[15:0], block[47:16], buf_sel[53:48], new_dirty[54], new_locked[55],
  // new_valid[56], zero fill
  input  logic [bbcm_pkg::IN_DATA_W-1:0]    in_tdata,
  // func[1:0]
  input  logic [bbcm_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // buf_index[5:0], valid_res[6], dirty[7], locked[8], ref_count[16:9], zero fill
  output logic [bbcm_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[2:0]
  output logic [bbcm_pkg::OUT_USER_W-1:0]   out_tuser
);

  import bbcm_pkg::*;

  `include "assert_macros.svh"

  localparam int IW = $clog2(NUM_BUFFERS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUFFERS - 1);

  typedef struct packed {
    logic [15:0]   dev;
    logic [31:0]   blk;
    logic [7:0]    refs;
    logic          dirty;
    logic          locked;
    logic          valid;
    logic [IW-1:0] link_next;
    logic [IW-1:0] link_prev;
  } entry_t;

  localparam int EW = $bits(entry_t);

  function automatic logic [5:0] to_six(input logic [IW-1:0] x);
    logic [15:0] w;
    w = 16'(x);
    return w[5:0];
  endfunction

  state_t        state_r, state_nxt;
  splice_step_t  step_r, step_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic          found_r, found_nxt;
  entry_t        pick_e_r, pick_e_nxt;

  logic [1:0]    func_r;
  logic [15:0]   dev_r;
  logic [31:0]   blk_r;
  logic [IW-1:0] sel_r;
  logic          nd_r, nl_r, nv_r;

  logic          out_tvalid_r, out_tvalid_nxt;
  logic [2:0]    out_stat_r, out_stat_nxt;
  logic [5:0]    out_idx_r, out_idx_nxt;
  logic          out_v_r, out_v_nxt;
  logic          out_d_r, out_d_nxt;
  logic          out_l_r, out_l_nxt;
  logic [7:0]    out_refs_r, out_refs_nxt;
  logic          out_load;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_e;

  logic [1:0]    in_func;
  logic [15:0]   in_dev;
  logic [31:0]   in_blk;
  logic [5:0]    in_sel;
  logic [15:0]   sel_w;
  logic [IW-1:0] sel_idx;
  logic          sel_ok;
  logic          accept;
  logic          hit;
  logic          cand;
  logic          walk_stop;
  logic          simple_fill;
  logic [IW-1:0] sp_target;

  bbcm_ram #(
    .DEPTH (NUM_BUFFERS),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_e    = entry_t'(ram_rdata);
  assign in_func = in_tuser[1:0];
  assign in_dev  = in_tdata[15:0];
  assign in_blk  = in_tdata[47:16];
  assign in_sel  = in_tdata[53:48];
  assign sel_w   = 16'(in_sel);
  assign sel_idx = sel_w[IW-1:0];
  assign sel_ok  = sel_w < 16'(NUM_BUFFERS);

  assign in_tready = (state_r == S_IDLE) && !out_tvalid_r;
  assign accept    = in_tvalid && in_tready;

  assign hit  = (rd_e.dev == dev_r) && (rd_e.blk == blk_r);
  assign cand = (rd_e.refs == 8'd0) &&
                (!found_r || (badness(rd_e.dirty, rd_e.locked) <
                              badness(pick_e_r.dirty, pick_e_r.locked)));
  assign walk_stop = (cand && (badness(rd_e.dirty, rd_e.locked) == 2'd0)) ||
                     (rd_e.link_next == head_r);
  assign simple_fill = (pick_r == head_r) || (pick_e_r.link_next == head_r);

  always_comb begin
    unique case (step_r)
      SP_HEAD: sp_target = head_r;
      SP_PREV: sp_target = pick_e_r.link_prev;
      SP_NEXT: sp_target = pick_e_r.link_next;
      SP_TAIL: sp_target = tail_r;
      default: sp_target = tail_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FN_GET: begin
              if (in_dev != 16'd0) begin
                state_nxt = S_MATCH;
              end
            end
            FN_REL, FN_FLAGS: begin
              if (sel_ok) begin
                state_nxt = S_OP;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_OP: state_nxt = S_IDLE;
      S_MATCH: begin
        if (hit) begin
          state_nxt = S_IDLE;
        end else if (cur_r == LAST_IDX) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_stop) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (found_r && !pick_e_r.locked && !simple_fill) begin
          state_nxt = S_SPLICE_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SPLICE_RD: state_nxt = S_SPLICE_WR;
      S_SPLICE_WR: begin
        if (step_r == SP_TAIL) begin
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_SPLICE_RD;
        end
      end
      S_FILL: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt      = clr_r;
    head_nxt     = head_r;
    cur_nxt      = cur_r;
    pick_nxt     = pick_r;
    pick_e_nxt   = pick_e_r;
    found_nxt    = found_r;
    step_nxt     = step_r;
    tail_nxt     = tail_r;
    ram_we       = 1'b0;
    ram_waddr    = cur_r;
    ram_wdata    = rd_e;
    ram_raddr    = cur_r;
    out_load     = 1'b0;
    out_stat_nxt = STAT_NONE;
    out_idx_nxt  = 6'd0;
    out_v_nxt    = 1'b0;
    out_d_nxt    = 1'b0;
    out_l_nxt    = 1'b0;
    out_refs_nxt = 8'd0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we              = 1'b1;
        ram_waddr           = clr_r;
        ram_wdata           = '0;
        ram_wdata.link_next = (clr_r == LAST_IDX) ? '0 : clr_r + 1'b1;
        ram_wdata.link_prev = (clr_r == '0) ? LAST_IDX : clr_r - 1'b1;
        clr_nxt             = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FN_GET: begin
              if (in_dev == 16'd0) begin
                out_load     = 1'b1;
                out_stat_nxt = STAT_NONE;
              end else begin
                ram_raddr = '0;
                cur_nxt   = '0;
              end
            end
            FN_REL, FN_FLAGS: begin
              if (sel_ok) begin
                ram_raddr = sel_idx;
              end else begin
                out_load     = 1'b1;
                out_stat_nxt = STAT_REL_ERR;
                out_idx_nxt  = in_sel;
              end
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      S_OP: begin
        out_load    = 1'b1;
        out_idx_nxt = to_six(sel_r);
        ram_waddr   = sel_r;
        if (func_r == FN_REL) begin
          if (rd_e.refs == 8'd0) begin
            out_stat_nxt = STAT_REL_ERR;
            out_refs_nxt = rd_e.refs;
          end else begin
            ram_we         = 1'b1;
            ram_wdata.refs = rd_e.refs - 8'd1;
            out_stat_nxt   = STAT_REL;
            out_refs_nxt   = rd_e.refs - 8'd1;
          end
          out_v_nxt = rd_e.valid;
          out_d_nxt = rd_e.dirty;
          out_l_nxt = rd_e.locked;
        end else begin
          ram_we           = 1'b1;
          ram_wdata.dirty  = nd_r;
          ram_wdata.locked = nl_r;
          ram_wdata.valid  = nv_r;
          out_stat_nxt     = STAT_FLAGS;
          out_v_nxt        = nv_r;
          out_d_nxt        = nd_r;
          out_l_nxt        = nl_r;
          out_refs_nxt     = rd_e.refs;
        end
      end
      S_MATCH: begin
        if (hit) begin
          ram_we         = 1'b1;
          ram_waddr      = cur_r;
          ram_wdata.refs = (rd_e.refs == 8'hFF) ? rd_e.refs : rd_e.refs + 8'd1;
          out_load       = 1'b1;
          out_stat_nxt   = STAT_HIT;
          out_idx_nxt    = to_six(cur_r);
          out_v_nxt      = rd_e.valid;
          out_d_nxt      = rd_e.dirty;
          out_l_nxt      = rd_e.locked;
          out_refs_nxt   = ram_wdata.refs;
        end else if (cur_r == LAST_IDX) begin
          ram_raddr = head_r;
          cur_nxt   = head_r;
          found_nxt = 1'b0;
        end else begin
          ram_raddr = cur_r + 1'b1;
          cur_nxt   = cur_r + 1'b1;
        end
      end
      S_WALK: begin
        if (cand) begin
          pick_nxt   = cur_r;
          pick_e_nxt = rd_e;
          found_nxt  = 1'b1;
        end
        if (!walk_stop) begin
          ram_raddr = rd_e.link_next;
          cur_nxt   = rd_e.link_next;
        end
      end
      S_DECIDE: begin
        if (!found_r) begin
          out_load     = 1'b1;
          out_stat_nxt = STAT_NONE;
        end else if (pick_e_r.locked) begin
          out_load     = 1'b1;
          out_stat_nxt = STAT_LOCKED;
          out_idx_nxt  = to_six(pick_r);
          out_v_nxt    = pick_e_r.valid;
          out_d_nxt    = pick_e_r.dirty;
          out_l_nxt    = pick_e_r.locked;
          out_refs_nxt = pick_e_r.refs;
        end else if (simple_fill) begin
          ram_we              = 1'b1;
          ram_waddr           = pick_r;
          ram_wdata           = '0;
          ram_wdata.dev       = dev_r;
          ram_wdata.blk       = blk_r;
          ram_wdata.refs      = 8'd1;
          ram_wdata.link_next = pick_e_r.link_next;
          ram_wdata.link_prev = pick_e_r.link_prev;
          if (pick_r == head_r) begin
            head_nxt = pick_e_r.link_next;
          end
          out_load     = 1'b1;
          out_stat_nxt = STAT_MISS;
          out_idx_nxt  = to_six(pick_r);
          out_refs_nxt = 8'd1;
        end else begin
          step_nxt = SP_HEAD;
        end
      end
      S_SPLICE_RD: begin
        ram_raddr = sp_target;
      end
      S_SPLICE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sp_target;
        unique case (step_r)
          SP_HEAD: begin
            ram_wdata.link_prev = pick_r;
            tail_nxt            = rd_e.link_prev;
            step_nxt            = SP_PREV;
          end
          SP_PREV: begin
            ram_wdata.link_next = pick_e_r.link_next;
            step_nxt            = SP_NEXT;
          end
          SP_NEXT: begin
            ram_wdata.link_prev = pick_e_r.link_prev;
            step_nxt            = SP_TAIL;
          end
          SP_TAIL: begin
            ram_wdata.link_next = pick_r;
            step_nxt            = SP_HEAD;
          end
          default: step_nxt = SP_HEAD;
        endcase
      end
      S_FILL: begin
        ram_we              = 1'b1;
        ram_waddr           = pick_r;
        ram_wdata           = '0;
        ram_wdata.dev       = dev_r;
        ram_wdata.blk       = blk_r;
        ram_wdata.refs      = 8'd1;
        ram_wdata.link_next = head_r;
        ram_wdata.link_prev = tail_r;
        out_load            = 1'b1;
        out_stat_nxt        = STAT_MISS;
        out_idx_nxt         = to_six(pick_r);
        out_refs_nxt        = 8'd1;
      end
      default: out_load = 1'b0;
    endcase
  end

  assign out_tvalid_nxt = out_load || (out_tvalid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      head_r       <= '0;
      found_r      <= 1'b0;
      step_r       <= SP_HEAD;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      head_r       <= head_nxt;
      found_r      <= found_nxt;
      step_r       <= step_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    pick_r   <= pick_nxt;
    pick_e_r <= pick_e_nxt;
    tail_r   <= tail_nxt;
    if (accept) begin
      func_r <= in_func;
      dev_r  <= in_dev;
      blk_r  <= in_blk;
      sel_r  <= sel_idx;
      nd_r   <= in_tdata[54];
      nl_r   <= in_tdata[55];
      nv_r   <= in_tdata[56];
    end
    if (out_load) begin
      out_stat_r <= out_stat_nxt;
      out_idx_r  <= out_idx_nxt;
      out_v_r    <= out_v_nxt;
      out_d_r    <= out_d_nxt;
      out_l_r    <= out_l_nxt;
      out_refs_r <= out_refs_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {7'd0, out_refs_r, out_l_r, out_d_r, out_v_r, out_idx_r};

  `BBCM_ASSERT(a_ready_idle_only, clk, rst_n, in_tready |-> (state_r == S_IDLE) && !out_tvalid_r, "request taken while busy")
  `BBCM_ASSERT_NEVER(a_no_overwrite, clk, rst_n, out_load && out_tvalid_r, "result register overwritten")
  `BBCM_ASSERT(a_miss_one_ref, clk, rst_n, (out_tvalid_r && (out_stat_r == STAT_MISS)) |-> (out_refs_r == 8'd1) && !out_l_r, "miss result with bad count")
  `BBCM_ASSERT(a_clear_blocks, clk, rst_n, (state_r == S_CLEAR) |-> !in_tready && !out_load, "activity during clearing pass")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buffer cache manager testbench
// Drives get, release, flag and no-op requests through the request stream and checks
// every returned descriptor against a scoreboard that tracks tags, counts,
// marks and the buffer ring. Runs under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
import bbcm_pkg::*;

typedef struct packed {
  logic [2:0] status;
  logic [5:0] buf_index;
  logic       valid_res;
  logic       dirty;
  logic       locked;
  logic [7:0] ref_count;
} buf_result_t;

class cache_scoreboard;
  localparam int NBUF = 64;
  logic [15:0] tag_dev[NBUF];
  logic [31:0] tag_blk[NBUF];
  logic [7:0]  refs[NBUF];
  logic        dirty[NBUF];
  logic        locked[NBUF];
  logic        valid[NBUF];
  logic [5:0]  nxt[NBUF];
  logic [5:0]  prv[NBUF];
  logic [5:0]  head;
  buf_result_t awaited_q[$];
  int          errors;

  function new();
    for (int i = 0; i < NBUF; i++) begin
      tag_dev[i] = '0;
      tag_blk[i] = '0;
      refs[i] = '0;
      dirty[i] = 1'b0;
      locked[i] = 1'b0;
      valid[i] = 1'b0;
      nxt[i] = 6'(i + 1);
      prv[i] = 6'(i + NBUF - 1);
    end
    head = '0;
    errors = 0;
  endfunction

  function buf_result_t snap(logic [2:0] st, logic [5:0] i, bit full);
    buf_result_t r;
    r = '0;
    r.status = st;
    r.buf_index = i;
    if (full) begin
      r.valid_res = valid[i];
      r.dirty = dirty[i];
      r.locked = locked[i];
      r.ref_count = refs[i];
    end
    return r;
  endfunction

  function buf_result_t lookup_or_fill(logic [15:0] dv, logic [31:0] blk);
    logic [5:0] cur, pick, n, p;
    bit found;
    if (dv == '0) return snap(STAT_NONE, '0, 0);
    for (int i = 0; i < NBUF; i++) begin
      if (tag_dev[i] == dv && tag_blk[i] == blk) begin
        if (refs[i] != 8'hff) refs[i]++;
        return snap(STAT_HIT, 6'(i), 1);
      end
    end
    cur = head;
    pick = '0;
    found = 0;
    for (int c = 0; c < NBUF; c++) begin
      if (refs[cur] == '0 && (!found || {dirty[cur], locked[cur]} < {dirty[pick], locked[pick]}))
          begin
        pick = cur;
        found = 1;
        if ({dirty[cur], locked[cur]} == 2'b00) break;
      end
      cur = nxt[cur];
      if (cur == head) break;
    end
    if (!found) return snap(STAT_NONE, '0, 0);
    if (locked[pick]) return snap(STAT_LOCKED, pick, 1);
    refs[pick] = 8'd1;
    dirty[pick] = 1'b0;
    valid[pick] = 1'b0;
    tag_dev[pick] = dv;
    tag_blk[pick] = blk;
    // unlink, then relink just ahead of the head
    n = nxt[pick];
    p = prv[pick];
    nxt[p] = n;
    prv[n] = p;
    if (head == pick) head = n;
    nxt[pick] = head;
    prv[pick] = prv[head];
    nxt[prv[head]] = pick;
    prv[head] = pick;
    return snap(STAT_MISS, pick, 1);
  endfunction

  function void note_request(logic [1:0] fn, logic [15:0] dv, logic [31:0] blk,
                             logic [5:0] sel, logic nd, logic nl, logic nv);
    if (fn == FN_NONE) return;
    if (fn == FN_GET) begin
      awaited_q.push_back(lookup_or_fill(dv, blk));
    end else if (fn == FN_REL) begin
      if (refs[sel] == '0) begin
        awaited_q.push_back(snap(STAT_REL_ERR, sel, 1));
      end else begin
        refs[sel]--;
        awaited_q.push_back(snap(STAT_REL, sel, 1));
      end
    end else begin
      dirty[sel] = nd;
      locked[sel] = nl;
      valid[sel] = nv;
      awaited_q.push_back(snap(STAT_FLAGS, sel, 1));
    end
  endfunction

  function void check_result(logic [2:0] st, logic [23:0] d);
    buf_result_t got, want;
    got = {st, d[5:0], d[6], d[7], d[8], d[16:9]};
    if (awaited_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected transfer: %p", got);
      return;
    end
    want = awaited_q.pop_front();
    if (got != want) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p, actual %p", want, got);
    end
  endfunction
endclass

module testbench;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;

  cache_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int issued = 0;

  block_buffer_cache_manager_top DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  task automatic send(logic [1:0] fn, logic [15:0] dv, logic [31:0] blk,
                      logic [5:0] sel, logic nd, logic nl, logic nv);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {7'b0, nv, nl, nd, sel, blk, dv};
    do @(posedge clk); while (!in_tready);
    sb.note_request(fn, dv, blk, sel, nd, nl, nv);
    issued++;
  endtask

  task automatic get(logic [15:0] dv, logic [31:0] blk);
    send(FN_GET, dv, blk, 6'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic release_buf(logic [5:0] sel);
    send(FN_REL, 16'($urandom), $urandom, sel, 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic set_flags(logic [5:0] sel, logic nd, logic nl, logic nv);
    send(FN_FLAGS, 16'($urandom), $urandom, sel, nd, nl, nv);
  endtask

  task automatic random_item();
    logic [15:0] dv;
    logic [31:0] blk;
    logic [5:0]  sel;
    int r;
    r = $urandom_range(99);
    dv = ($urandom_range(15) == 0) ? 16'd0 :
         ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3));
    blk = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 20);
    sel = 6'($urandom);
    if (r < 50) begin
      get(dv, blk);
    end else if (r < 75) begin
      if ($urandom_range(9) < 7) begin
        for (int k = 0; k < 64; k++) begin
          if (sb.refs[6'(sel + k)] != '0) begin
            sel = 6'(sel + k);
            break;
          end
        end
      end
      release_buf(sel);
    end else if (r < 95) begin
      set_flags(sel, 1'($urandom), ($urandom_range(4) == 0), 1'($urandom));
    end else begin
      send(FN_NONE, dv, blk, sel, 1'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic fill_and_drain();
    for (int i = 0; i < 65; i++) get(16'($urandom_range(1, 65535)), $urandom);
    for (int i = 0; i < 64; i++) begin
      while (sb.refs[i] != '0 && sb.refs[i] != 8'hff) release_buf(6'(i));
    end
  endtask

  task automatic lock_sweep();
    for (int i = 0; i < 64; i++) set_flags(6'(i), 1'($urandom), 1'b1, 1'($urandom));
    get(16'($urandom_range(1, 65535)), $urandom);
    for (int i = 0; i < 64; i++) set_flags(6'(i), $urandom_range(3) == 0, 1'b0, 1'($urandom));
  endtask

  initial begin
    int idle_mix[4] = '{0, 77, 0, 36};
    int stall_mix[4] = '{0, 0, 77, 36};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    get(16'd0, 32'd5);
    get(16'hffff, 32'hffff_ffff);
    get(16'hffff, 32'hffff_ffff);
    get(16'd1, 32'd0);
    release_buf(6'd0);
    release_buf(6'd0);
    release_buf(6'd0);
    release_buf(6'd63);
    set_flags(6'd2, 1'b1, 1'b1, 1'b1);
    set_flags(6'd1, 1'b1, 1'b1, 1'b1);
    get(16'd1, 32'd0);
    get(16'h8000, 32'h8000_0000);
    send(FN_NONE, 16'hffff, 32'hffff_ffff, 6'h3f, 1'b1, 1'b1, 1'b1);
    set_flags(6'd2, 1'b0, 1'b0, 1'b0);
    set_flags(6'd1, 1'b0, 1'b0, 1'b1);
    release_buf(6'd1);
    release_buf(6'd1);
    release_buf(6'd1);
    for (int i = 0; i < 257; i++) get(16'd7, 32'd7);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_mix[ph];
      stall_pct = stall_mix[ph];
      if (ph == 0) begin
        fill_and_drain();
        lock_sweep();
      end
      while (issued < 150 * (ph + 1) + 400) begin
        if ($urandom_range(199) == 0) fill_and_drain();
        else if ($urandom_range(199) == 0) lock_sweep();
        else random_item();
      end
    end
    in_tvalid <= 1'b0;
    while (sb.awaited_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bbcm_pkg.sv
rtl/core/bbcm_ram.sv
rtl/core/block_buffer_cache_manager_top.sv
test/testbench.sv
